/* rtl/fpm_pkg.sv */
// Package: shared types, constants and flash sector helpers for the page mapper.
package fpm_pkg;

    localparam int unsigned RAM_PAGE_BYTES     = 1024;
    localparam int unsigned RAM_PAGE_SHIFT     = $clog2(RAM_PAGE_BYTES);
    localparam int unsigned WRITE_CHUNK_BYTES  = 256;
    localparam int unsigned SMALL_SECTOR_COUNT = 16;
    localparam int unsigned SMALL_SECTOR_BYTES = 4096;
    localparam int unsigned LARGE_SECTOR_BYTES = 32768;
    localparam int unsigned SMALL_SHIFT        = $clog2(SMALL_SECTOR_BYTES);
    localparam int unsigned LARGE_SHIFT        = $clog2(LARGE_SECTOR_BYTES);
    localparam int unsigned SMALL_AREA_BYTES   = SMALL_SECTOR_COUNT * SMALL_SECTOR_BYTES;

    localparam int unsigned PAGE_W  = 18;
    localparam int unsigned WIDE_W  = 35;
    localparam int unsigned PADDR_W = 5;

    localparam logic [31:0] RST_MAIN_RAM_BASE   = 32'h1000_0000;
    localparam logic [10:0] RST_MAIN_RAM_PAGES  = 11'd32;
    localparam logic [31:0] RST_AUX_RAM_BASE    = 32'h2007_C000;
    localparam logic [10:0] RST_AUX_RAM_PAGES   = 11'd32;
    localparam logic [31:0] RST_FLASH_BYTES     = 32'd524288;
    localparam logic [31:0] RST_BOOT_CODE_BYTES = 32'd0;
    localparam logic [31:0] RST_OS_START_ADDR   = 32'd0;
    localparam logic [31:0] RST_OS_END_ADDR     = 32'd0;

    typedef logic [WIDE_W-1:0] t_wide;
    typedef logic [PAGE_W-1:0] t_page;

    typedef enum logic [2:0] {
        OP_RAM_INFO    = 3'd0,
        OP_FLASH_INFO  = 3'd1,
        OP_QUERY       = 3'd2,
        OP_ERASE_CHECK = 3'd3,
        OP_WRITE_CHECK = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_READ_ONLY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_MAIN_RAM_BASE   = 3'd0,
        REG_MAIN_RAM_PAGES  = 3'd1,
        REG_AUX_RAM_BASE    = 3'd2,
        REG_AUX_RAM_PAGES   = 3'd3,
        REG_FLASH_BYTES     = 3'd4,
        REG_BOOT_CODE_BYTES = 3'd5,
        REG_OS_START_ADDR   = 3'd6,
        REG_OS_END_ADDR     = 3'd7
    } t_reg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [17:0] page_index;
        logic [31:0] address;
        logic [15:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] page_out;
        logic [31:0] page_address;
        logic [15:0] page_bytes;
        logic        memory_kind;
        logic [8:0]  granted_bytes;
    } t_rsp;

    typedef struct packed {
        logic [31:0] main_ram_base;
        logic [10:0] main_ram_pages;
        logic [31:0] aux_ram_base;
        logic [10:0] aux_ram_pages;
        logic [31:0] flash_bytes;
        logic [31:0] boot_code_bytes;
        logic [31:0] os_start_addr;
        logic [31:0] os_end_addr;
    } t_cfg;

    // small sectors first, then large ones
    function automatic t_page flash_page_of(input logic [31:0] a);
        logic [31:0] d;
        d = a - 32'(SMALL_AREA_BYTES);
        if (a < 32'(SMALL_AREA_BYTES)) begin
            return t_page'(a >> SMALL_SHIFT);
        end
        return t_page'(SMALL_SECTOR_COUNT) + t_page'(d >> LARGE_SHIFT);
    endfunction

    function automatic t_wide flash_page_start(input t_page p);
        if (p < t_page'(SMALL_SECTOR_COUNT)) begin
            return t_wide'(p) << SMALL_SHIFT;
        end
        return t_wide'(SMALL_AREA_BYTES) +
               (t_wide'(p - t_page'(SMALL_SECTOR_COUNT)) << LARGE_SHIFT);
    endfunction

    function automatic logic [15:0] flash_page_size(input t_page p);
        if (p < t_page'(SMALL_SECTOR_COUNT)) begin
            return 16'(SMALL_SECTOR_BYTES);
        end
        return 16'(LARGE_SECTOR_BYTES);
    endfunction

endpackage

/* rtl/fpm_cfg_regs.sv */
// Configuration register file behind the APB-style port.
module fpm_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output fpm_pkg::t_cfg                o_cfg
);

    fpm_pkg::t_cfg r_cfg;
    fpm_pkg::t_cfg n_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[4:2])
                fpm_pkg::REG_MAIN_RAM_BASE:   n_cfg.main_ram_base   = pwdata;
                fpm_pkg::REG_MAIN_RAM_PAGES:  n_cfg.main_ram_pages  = pwdata[10:0];
                fpm_pkg::REG_AUX_RAM_BASE:    n_cfg.aux_ram_base    = pwdata;
                fpm_pkg::REG_AUX_RAM_PAGES:   n_cfg.aux_ram_pages   = pwdata[10:0];
                fpm_pkg::REG_FLASH_BYTES:     n_cfg.flash_bytes     = pwdata;
                fpm_pkg::REG_BOOT_CODE_BYTES: n_cfg.boot_code_bytes = pwdata;
                fpm_pkg::REG_OS_START_ADDR:   n_cfg.os_start_addr   = pwdata;
                fpm_pkg::REG_OS_END_ADDR:     n_cfg.os_end_addr     = pwdata;
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            fpm_pkg::REG_MAIN_RAM_BASE:   prdata = r_cfg.main_ram_base;
            fpm_pkg::REG_MAIN_RAM_PAGES:  prdata = 32'(r_cfg.main_ram_pages);
            fpm_pkg::REG_AUX_RAM_BASE:    prdata = r_cfg.aux_ram_base;
            fpm_pkg::REG_AUX_RAM_PAGES:   prdata = 32'(r_cfg.aux_ram_pages);
            fpm_pkg::REG_FLASH_BYTES:     prdata = r_cfg.flash_bytes;
            fpm_pkg::REG_BOOT_CODE_BYTES: prdata = r_cfg.boot_code_bytes;
            fpm_pkg::REG_OS_START_ADDR:   prdata = r_cfg.os_start_addr;
            fpm_pkg::REG_OS_END_ADDR:     prdata = r_cfg.os_end_addr;
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.main_ram_base   <= fpm_pkg::RST_MAIN_RAM_BASE;
            r_cfg.main_ram_pages  <= fpm_pkg::RST_MAIN_RAM_PAGES;
            r_cfg.aux_ram_base    <= fpm_pkg::RST_AUX_RAM_BASE;
            r_cfg.aux_ram_pages   <= fpm_pkg::RST_AUX_RAM_PAGES;
            r_cfg.flash_bytes     <= fpm_pkg::RST_FLASH_BYTES;
            r_cfg.boot_code_bytes <= fpm_pkg::RST_BOOT_CODE_BYTES;
            r_cfg.os_start_addr   <= fpm_pkg::RST_OS_START_ADDR;
            r_cfg.os_end_addr     <= fpm_pkg::RST_OS_END_ADDR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* rtl/fpm_map_logic.sv */
// Combinational page lookup and protection checks for one request.
module fpm_map_logic (
    input  fpm_pkg::t_cfg i_cfg,
    input  fpm_pkg::t_req i_req,
    output fpm_pkg::t_rsp o_rsp
);

    localparam logic [31:0] PAGE_MASK = ~32'(fpm_pkg::RAM_PAGE_BYTES - 1);

    // region fit test, done at 34 bits so nothing wraps
    function automatic logic in_region(input logic [31:0] a, input logic [15:0] len,
                                       input logic [31:0] base, input logic [10:0] pages);
        logic [33:0] lim;
        lim = 34'(base) + (34'(pages) << fpm_pkg::RAM_PAGE_SHIFT);
        return (a >= base) && ((34'(a) + 34'(len)) <= lim);
    endfunction

    fpm_pkg::t_page pg;
    logic [31:0]    a;
    fpm_pkg::t_wide pg_start;
    logic [15:0]    pg_size;
    fpm_pkg::t_page a_page;
    fpm_pkg::t_wide a_start;
    logic [15:0]    a_size;
    fpm_pkg::t_page boot_page;
    logic           boot_on;
    logic           pg_boot;
    logic           a_boot;
    logic [11:0]    ram_total;
    logic [33:0]    aux_end;
    logic           aux_hit;
    logic [31:0]    q_base;
    logic [10:0]    q_first;
    logic [31:0]    q_off;
    logic           q_ram;
    logic [8:0]     wr_len;
    logic           wr_ram;
    logic           wr_oob;
    logic           pg_os;
    fpm_pkg::t_rsp  rsp;

    assign pg        = i_req.page_index;
    assign a         = i_req.address;
    assign pg_start  = fpm_pkg::flash_page_start(pg);
    assign pg_size   = fpm_pkg::flash_page_size(pg);
    assign a_page    = fpm_pkg::flash_page_of(a);
    assign a_start   = fpm_pkg::flash_page_start(a_page);
    assign a_size    = fpm_pkg::flash_page_size(a_page);
    assign boot_page = fpm_pkg::flash_page_of(i_cfg.boot_code_bytes);
    assign boot_on   = i_cfg.boot_code_bytes != 32'd0;
    assign pg_boot   = boot_on && (pg <= boot_page);
    assign a_boot    = boot_on && (a_page <= boot_page);
    assign ram_total = 12'(i_cfg.main_ram_pages) + 12'(i_cfg.aux_ram_pages);
    assign pg_os     = (pg_start >= fpm_pkg::t_wide'(i_cfg.os_start_addr)) &&
                       (pg_start <= fpm_pkg::t_wide'(i_cfg.os_end_addr));

    // query: auxiliary region takes precedence where the two overlap
    assign aux_end = 34'(i_cfg.aux_ram_base) +
                     (34'(i_cfg.aux_ram_pages) << fpm_pkg::RAM_PAGE_SHIFT);
    assign aux_hit = (a >= i_cfg.aux_ram_base) && (34'(a) < aux_end);
    assign q_base  = aux_hit ? i_cfg.aux_ram_base : i_cfg.main_ram_base;
    assign q_first = aux_hit ? i_cfg.main_ram_pages : 11'd0;
    assign q_off   = a - q_base;
    assign q_ram   = in_region(a, 16'(fpm_pkg::RAM_PAGE_BYTES),
                               i_cfg.main_ram_base, i_cfg.main_ram_pages) ||
                     in_region(a, 16'(fpm_pkg::RAM_PAGE_BYTES),
                               i_cfg.aux_ram_base, i_cfg.aux_ram_pages);

    assign wr_len  = (i_req.byte_count < 16'(fpm_pkg::WRITE_CHUNK_BYTES)) ?
                     9'(i_req.byte_count) : 9'(fpm_pkg::WRITE_CHUNK_BYTES);
    assign wr_ram  = in_region(a, 16'(wr_len), i_cfg.main_ram_base, i_cfg.main_ram_pages) ||
                     in_region(a, 16'(wr_len), i_cfg.aux_ram_base, i_cfg.aux_ram_pages);
    assign wr_oob  = (a >= i_cfg.flash_bytes) ||
                     ((34'(a) + 34'(fpm_pkg::WRITE_CHUNK_BYTES)) > 34'(i_cfg.flash_bytes));

    always_comb begin
        rsp        = '0;
        rsp.status = fpm_pkg::ST_OK;
        case (i_req.opcode)
            fpm_pkg::OP_RAM_INFO: begin
                rsp.page_out   = pg;
                rsp.page_bytes = 16'(fpm_pkg::RAM_PAGE_BYTES);
                if (pg < fpm_pkg::t_page'(i_cfg.main_ram_pages)) begin
                    rsp.page_address = i_cfg.main_ram_base +
                                       (32'(pg) << fpm_pkg::RAM_PAGE_SHIFT);
                end else if (pg < fpm_pkg::t_page'(ram_total)) begin
                    rsp.page_address = i_cfg.aux_ram_base +
                        (32'(pg - fpm_pkg::t_page'(i_cfg.main_ram_pages))
                         << fpm_pkg::RAM_PAGE_SHIFT);
                end else begin
                    rsp.status = fpm_pkg::ST_INVALID;
                end
            end
            fpm_pkg::OP_FLASH_INFO: begin
                rsp.page_out     = pg;
                rsp.page_address = pg_start[31:0];
                rsp.page_bytes   = pg_size;
                rsp.memory_kind  = 1'b1;
                if ((pg_start + fpm_pkg::t_wide'(pg_size)) >
                    fpm_pkg::t_wide'(i_cfg.flash_bytes)) begin
                    rsp.status = fpm_pkg::ST_INVALID;
                end
            end
            fpm_pkg::OP_QUERY: begin
                if (q_ram) begin
                    rsp.page_out     = fpm_pkg::t_page'(q_off >> fpm_pkg::RAM_PAGE_SHIFT) +
                                       fpm_pkg::t_page'(q_first);
                    rsp.page_address = q_base + (q_off & PAGE_MASK);
                    rsp.page_bytes   = 16'(fpm_pkg::RAM_PAGE_BYTES);
                end else if (a <= i_cfg.flash_bytes) begin
                    rsp.page_out     = a_page;
                    rsp.page_address = a_start[31:0];
                    rsp.page_bytes   = a_size;
                    rsp.memory_kind  = 1'b1;
                end else begin
                    rsp.status = fpm_pkg::ST_INVALID;
                end
            end
            fpm_pkg::OP_ERASE_CHECK: begin
                rsp.page_out     = pg;
                rsp.page_address = pg_start[31:0];
                rsp.page_bytes   = pg_size;
                rsp.memory_kind  = 1'b1;
                if (pg_boot || pg_os) begin
                    rsp.status = fpm_pkg::ST_READ_ONLY;
                end
            end
            fpm_pkg::OP_WRITE_CHECK: begin
                if (wr_ram) begin
                    rsp.granted_bytes = wr_len;
                end else begin
                    rsp.page_out      = a_page;
                    rsp.page_address  = a_start[31:0];
                    rsp.page_bytes    = a_size;
                    rsp.memory_kind   = 1'b1;
                    rsp.granted_bytes = 9'(fpm_pkg::WRITE_CHUNK_BYTES);
                    if (a_boot) begin
                        rsp.status = fpm_pkg::ST_READ_ONLY;
                    end else if (wr_oob) begin
                        rsp.status = fpm_pkg::ST_INVALID;
                    end
                end
            end
            default: begin
                rsp.status = fpm_pkg::ST_INVALID;
            end
        endcase

        // a refused request carries nothing but its status
        if (rsp.status != fpm_pkg::ST_OK) begin
            rsp.page_out      = '0;
            rsp.page_address  = '0;
            rsp.page_bytes    = '0;
            rsp.memory_kind   = 1'b0;
            rsp.granted_bytes = '0;
        end
    end

    assign o_rsp = rsp;

endmodule

/* rtl/flash_ram_page_mapper.sv */
// Top level: request register, lookup logic, result register and config port.
// Pipeline: two register stages; the request register feeds the lookup logic, whose
// result is captured in the result register and held there while the output stalls.
// Throughput: one request per cycle while the output is not stalled; a single pass of
// compare/shift/add logic sits between the request register and the result register.
// Reset (synchronous, active low) empties both stages and loads the register defaults.
module flash_ram_page_mapper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  fpm_pkg::t_req                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output fpm_pkg::t_rsp                o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    fpm_pkg::t_cfg cfg;
    fpm_pkg::t_rsp map_rsp;

    fpm_pkg::t_req r_req;
    fpm_pkg::t_req n_req;
    logic          r_req_vld;
    logic          n_req_vld;
    fpm_pkg::t_rsp r_rsp;
    fpm_pkg::t_rsp n_rsp;
    logic          r_rsp_vld;
    logic          n_rsp_vld;
    logic          adv_out;

    fpm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fpm_map_logic u_map (
        .i_cfg (cfg),
        .i_req (r_req),
        .o_rsp (map_rsp)
    );

    // result register frees up when empty or when its transaction is taken
    assign adv_out    = !r_rsp_vld || !i_out_stall;
    assign o_in_stall = r_req_vld && !adv_out;

    always_comb begin
        n_req     = o_in_stall ? r_req : i_in_data;
        n_req_vld = o_in_stall ? r_req_vld : i_in_valid;
        n_rsp     = adv_out ? map_rsp : r_rsp;
        n_rsp_vld = adv_out ? r_req_vld : r_rsp_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    assign o_out_valid = r_rsp_vld;
    assign o_out_data  = r_rsp;

endmodule

/* rtl/fpm_checker.sv */
// Port-level checker for the page mapper, bound to the top level.
module fpm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input fpm_pkg::t_rsp o_out_data
);

    // a held result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a refused request shows no page data
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != fpm_pkg::ST_OK) |->
            (o_out_data.page_out == '0) && (o_out_data.page_address == '0) &&
            (o_out_data.page_bytes == '0) && !o_out_data.memory_kind &&
            (o_out_data.granted_bytes == '0))
        else $error("non-ok result carries data");

    a_grant_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.granted_bytes <= 9'(fpm_pkg::WRITE_CHUNK_BYTES))
        else $error("granted length above write chunk");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind flash_ram_page_mapper fpm_checker u_fpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench for the flash/RAM page mapper: directed and random requests, scoreboard check.
module tb;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 255;
    localparam int IDLE_PCT    = 37;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct packed {
        fpm_pkg::t_req req;
        fpm_pkg::t_rsp rsp;
    } t_expected;

    class mapper_scoreboard;
        fpm_pkg::t_cfg cfg;
        t_expected     waiting[$];
        int            errors;
        int            checked;
        int            accepted;

        function new();
            cfg.main_ram_base   = fpm_pkg::RST_MAIN_RAM_BASE;
            cfg.main_ram_pages  = fpm_pkg::RST_MAIN_RAM_PAGES;
            cfg.aux_ram_base    = fpm_pkg::RST_AUX_RAM_BASE;
            cfg.aux_ram_pages   = fpm_pkg::RST_AUX_RAM_PAGES;
            cfg.flash_bytes     = fpm_pkg::RST_FLASH_BYTES;
            cfg.boot_code_bytes = fpm_pkg::RST_BOOT_CODE_BYTES;
            cfg.os_start_addr   = fpm_pkg::RST_OS_START_ADDR;
            cfg.os_end_addr     = fpm_pkg::RST_OS_END_ADDR;
            errors   = 0;
            checked  = 0;
            accepted = 0;
        endfunction

        function void write_reg(fpm_pkg::t_reg idx, logic [31:0] v);
            case (idx)
                fpm_pkg::REG_MAIN_RAM_BASE:   cfg.main_ram_base   = v;
                fpm_pkg::REG_MAIN_RAM_PAGES:  cfg.main_ram_pages  = v[10:0];
                fpm_pkg::REG_AUX_RAM_BASE:    cfg.aux_ram_base    = v;
                fpm_pkg::REG_AUX_RAM_PAGES:   cfg.aux_ram_pages   = v[10:0];
                fpm_pkg::REG_FLASH_BYTES:     cfg.flash_bytes     = v;
                fpm_pkg::REG_BOOT_CODE_BYTES: cfg.boot_code_bytes = v;
                fpm_pkg::REG_OS_START_ADDR:   cfg.os_start_addr   = v;
                fpm_pkg::REG_OS_END_ADDR:     cfg.os_end_addr     = v;
                default: ;
            endcase
        endfunction

        // sector arithmetic is kept 64 bits wide so nothing wraps before a compare
        function logic [63:0] sector_of(logic [63:0] a);
            if (a < fpm_pkg::SMALL_AREA_BYTES) begin
                return a / fpm_pkg::SMALL_SECTOR_BYTES;
            end
            return fpm_pkg::SMALL_SECTOR_COUNT +
                   (a - fpm_pkg::SMALL_AREA_BYTES) / fpm_pkg::LARGE_SECTOR_BYTES;
        endfunction

        function logic [63:0] sector_start(logic [63:0] p);
            if (p < fpm_pkg::SMALL_SECTOR_COUNT) begin
                return p * fpm_pkg::SMALL_SECTOR_BYTES;
            end
            return fpm_pkg::SMALL_AREA_BYTES +
                   (p - fpm_pkg::SMALL_SECTOR_COUNT) * fpm_pkg::LARGE_SECTOR_BYTES;
        endfunction

        function logic [63:0] sector_size(logic [63:0] p);
            return (p < fpm_pkg::SMALL_SECTOR_COUNT) ? fpm_pkg::SMALL_SECTOR_BYTES
                                                     : fpm_pkg::LARGE_SECTOR_BYTES;
        endfunction

        function bit fits(logic [63:0] a, logic [63:0] len, logic [63:0] base,
                          logic [63:0] pages);
            return a >= base && a + len <= base + pages * fpm_pkg::RAM_PAGE_BYTES;
        endfunction

        function bit in_ram(logic [63:0] a, logic [63:0] len);
            return fits(a, len, cfg.main_ram_base, cfg.main_ram_pages) ||
                   fits(a, len, cfg.aux_ram_base, cfg.aux_ram_pages);
        endfunction

        function bit boot_locked(logic [63:0] p);
            return cfg.boot_code_bytes != 0 && p <= sector_of(cfg.boot_code_bytes);
        endfunction

        // any failing status clears the other fields
        function fpm_pkg::t_rsp make_rsp(fpm_pkg::t_status st,
                                         input logic [63:0] pg, ad, sz, kind, gr);
            fpm_pkg::t_rsp r;
            r = '0;
            r.status = st;
            if (st == fpm_pkg::ST_OK) begin
                r.page_out      = pg[17:0];
                r.page_address  = ad[31:0];
                r.page_bytes    = sz[15:0];
                r.memory_kind   = kind[0];
                r.granted_bytes = gr[8:0];
            end
            return r;
        endfunction

        function fpm_pkg::t_rsp map_request(fpm_pkg::t_req q);
            logic [63:0] a, pg, cnt, n, s, p, base, first, off, psz, mp, ap;
            fpm_pkg::t_status st;
            fpm_pkg::t_rsp rsp;
            a   = q.address;
            pg  = q.page_index;
            cnt = q.byte_count;
            psz = fpm_pkg::RAM_PAGE_BYTES;
            mp  = cfg.main_ram_pages;
            ap  = cfg.aux_ram_pages;
            case (q.opcode)
                fpm_pkg::OP_RAM_INFO: begin
                    if (pg < mp) begin
                        rsp = make_rsp(fpm_pkg::ST_OK, pg, cfg.main_ram_base + pg * psz,
                                       psz, 0, 0);
                    end else if (pg < mp + ap) begin
                        rsp = make_rsp(fpm_pkg::ST_OK, pg,
                                       cfg.aux_ram_base + (pg - mp) * psz, psz, 0, 0);
                    end else begin
                        rsp = make_rsp(fpm_pkg::ST_INVALID, 0, 0, 0, 0, 0);
                    end
                end
                fpm_pkg::OP_FLASH_INFO: begin
                    s  = sector_start(pg);
                    st = (s + sector_size(pg) > cfg.flash_bytes) ? fpm_pkg::ST_INVALID
                                                                 : fpm_pkg::ST_OK;
                    rsp = make_rsp(st, pg, s, sector_size(pg), 1, 0);
                end
                fpm_pkg::OP_QUERY: begin
                    if (in_ram(a, psz)) begin
                        // auxiliary region takes precedence where the two overlap
                        if (a >= cfg.aux_ram_base && a < cfg.aux_ram_base + ap * psz) begin
                            base  = cfg.aux_ram_base;
                            first = mp;
                        end else begin
                            base  = cfg.main_ram_base;
                            first = 0;
                        end
                        off = (a - base) / psz;
                        rsp = make_rsp(fpm_pkg::ST_OK, off + first, base + off * psz,
                                       psz, 0, 0);
                    end else if (a <= cfg.flash_bytes) begin
                        p   = sector_of(a);
                        rsp = make_rsp(fpm_pkg::ST_OK, p, sector_start(p), sector_size(p),
                                       1, 0);
                    end else begin
                        rsp = make_rsp(fpm_pkg::ST_INVALID, 0, 0, 0, 0, 0);
                    end
                end
                fpm_pkg::OP_ERASE_CHECK: begin
                    s  = sector_start(pg);
                    st = (boot_locked(pg) || (s >= cfg.os_start_addr && s <= cfg.os_end_addr))
                         ? fpm_pkg::ST_READ_ONLY : fpm_pkg::ST_OK;
                    rsp = make_rsp(st, pg, s, sector_size(pg), 1, 0);
                end
                fpm_pkg::OP_WRITE_CHECK: begin
                    n = (cnt < fpm_pkg::WRITE_CHUNK_BYTES) ? cnt
                                                           : fpm_pkg::WRITE_CHUNK_BYTES;
                    if (in_ram(a, n)) begin
                        rsp = make_rsp(fpm_pkg::ST_OK, 0, 0, 0, 0, n);
                    end else begin
                        p = sector_of(a);
                        n = fpm_pkg::WRITE_CHUNK_BYTES;
                        if (boot_locked(p)) begin
                            st = fpm_pkg::ST_READ_ONLY;
                        end else if (a >= cfg.flash_bytes || a + n > cfg.flash_bytes) begin
                            st = fpm_pkg::ST_INVALID;
                        end else begin
                            st = fpm_pkg::ST_OK;
                        end
                        rsp = make_rsp(st, p, sector_start(p), sector_size(p), 1, n);
                    end
                end
                default: rsp = make_rsp(fpm_pkg::ST_INVALID, 0, 0, 0, 0, 0);
            endcase
            return rsp;
        endfunction

        function void note_request(fpm_pkg::t_req q);
            t_expected e;
            e.req = q;
            e.rsp = map_request(q);
            waiting.push_back(e);
            accepted++;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("ERROR %0t: %s", $realtime, msg);
            end
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want, fpm_pkg::t_req q);
            if (got !== want) begin
                report($sformatf("op %0d page %0d addr %h count %0d: %s %h, want %h",
                                 q.opcode, q.page_index, q.address, q.byte_count,
                                 field, got, want));
            end
        endtask

        task check_result(fpm_pkg::t_rsp got);
            t_expected e;
            checked++;
            if (waiting.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", got));
            end else begin
                e = waiting.pop_front();
                compare("status",        got.status,        e.rsp.status,        e.req);
                compare("page_out",      got.page_out,      e.rsp.page_out,      e.req);
                compare("page_address",  got.page_address,  e.rsp.page_address,  e.req);
                compare("page_bytes",    got.page_bytes,    e.rsp.page_bytes,    e.req);
                compare("memory_kind",   got.memory_kind,   e.rsp.memory_kind,   e.req);
                compare("granted_bytes", got.granted_bytes, e.rsp.granted_bytes, e.req);
            end
        endtask

        task give_up();
            report($sformatf("%0d expected results never arrived", waiting.size()));
            waiting.delete();
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    fpm_pkg::t_req               i_in_data;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    fpm_pkg::t_rsp               o_out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [fpm_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    mapper_scoreboard board;
    bit               calm = 1'b0;
    int               settings_seen = 1;

    flash_ram_page_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: sample the transaction from before the edge, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_out_data);
        end
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_req(fpm_pkg::t_req r);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(r);
    endtask

    // called right after an accepted transaction, so valid is only lowered once per step
    task automatic drain();
        int spins;
        spins = 0;
        i_in_valid <= 1'b0;
        while (board.pending() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        if (board.pending() != 0) begin
            board.give_up();
        end
    endtask

    task automatic apb_write(fpm_pkg::t_reg idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, v);
    endtask

    task automatic configure(logic [31:0] main_base, logic [31:0] main_pages,
                             logic [31:0] aux_base, logic [31:0] aux_pages,
                             logic [31:0] flash, logic [31:0] boot,
                             logic [31:0] os_lo, logic [31:0] os_hi);
        apb_write(fpm_pkg::REG_MAIN_RAM_BASE, main_base);
        apb_write(fpm_pkg::REG_MAIN_RAM_PAGES, main_pages);
        apb_write(fpm_pkg::REG_AUX_RAM_BASE, aux_base);
        apb_write(fpm_pkg::REG_AUX_RAM_PAGES, aux_pages);
        apb_write(fpm_pkg::REG_FLASH_BYTES, flash);
        apb_write(fpm_pkg::REG_BOOT_CODE_BYTES, boot);
        apb_write(fpm_pkg::REG_OS_START_ADDR, os_lo);
        apb_write(fpm_pkg::REG_OS_END_ADDR, os_hi);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        settings_seen++;
    endtask

    function automatic fpm_pkg::t_req mk(logic [2:0] op, logic [17:0] pg, logic [31:0] a,
                                         logic [15:0] cnt);
        fpm_pkg::t_req r;
        r.opcode     = op;
        r.page_index = pg;
        r.address    = a;
        r.byte_count = cnt;
        return r;
    endfunction

    // addresses and pages cluster round the region, flash and protection edges
    function automatic fpm_pkg::t_req random_req();
        fpm_pkg::t_req r;
        logic [31:0]   mb, ab, fb, bc, os0, os1, anchor;
        logic [31:0]   mp, ap;
        mb  = board.cfg.main_ram_base;
        ab  = board.cfg.aux_ram_base;
        mp  = board.cfg.main_ram_pages;
        ap  = board.cfg.aux_ram_pages;
        fb  = board.cfg.flash_bytes;
        bc  = board.cfg.boot_code_bytes;
        os0 = board.cfg.os_start_addr;
        os1 = board.cfg.os_end_addr;
        case ($urandom_range(0, 9))
            0: r.address = mb + $urandom_range(0, mp * 1024 + 2048) - 32'd1024;
            1: r.address = ab + $urandom_range(0, ap * 1024 + 2048) - 32'd1024;
            2: r.address = fb + $urandom_range(0, 600) - 32'd300;
            3: r.address = $urandom_range(0, 32'h0001_1000);
            4: r.address = $urandom_range(0, fb);
            5: r.address = bc + $urandom_range(0, 8192) - 32'd4096;
            6: r.address = ($urandom_range(0, 1) ? os0 : os1) + $urandom_range(0, 64) - 32'd32;
            7: r.address = ($urandom & 32'hFFFF_FC00) - $urandom_range(0, 1);
            default: r.address = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: anchor = fb;
            1: anchor = bc;
            2: anchor = os0;
            3: anchor = os1;
            default: anchor = $urandom_range(0, 32'h0010_0000);
        endcase
        case ($urandom_range(0, 7))
            0: r.page_index = 18'($urandom_range(0, 40));
            1: r.page_index = 18'(mp + ap + $urandom_range(0, 4) - 2);
            2: r.page_index = 18'(mp + $urandom_range(0, 4) - 2);
            3, 4: r.page_index = 18'(board.sector_of(anchor) + $urandom_range(0, 4) - 2);
            5: r.page_index = 18'(board.sector_of(anchor));
            6: r.page_index = 18'($urandom_range(0, 18'h3FFFF));
            default: r.page_index = 18'h3FFFF - 18'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 4))
            0: r.byte_count = '0;
            1: r.byte_count = 16'($urandom_range(1, 256));
            2: r.byte_count = 16'($urandom_range(255, 257));
            3: r.byte_count = 16'($urandom);
            default: r.byte_count = 16'hFFFF;
        endcase
        if ($urandom_range(0, 99) < 8) begin
            r.opcode = 3'($urandom_range(0, 7));
        end else begin
            r.opcode = 3'($urandom_range(0, fpm_pkg::OP_WRITE_CHECK));
        end
        return r;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            // halfway through, hold the sender until the pipe has emptied
            if (i == count / 2) begin
                drain();
            end
            send_req(random_req());
        end
        drain();
    endtask

    initial begin
        board = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: main 0x1000_0000 and aux 0x2007_C000, 32 pages each, 512 KiB flash
        send_req(mk(fpm_pkg::OP_RAM_INFO, 0, 0, 0));
        send_req(mk(fpm_pkg::OP_RAM_INFO, 31, 0, 0));
        send_req(mk(fpm_pkg::OP_RAM_INFO, 32, 0, 0));
        send_req(mk(fpm_pkg::OP_RAM_INFO, 64, 0, 0));
        send_req(mk(fpm_pkg::OP_RAM_INFO, 18'h3FFFF, 0, 0));
        send_req(mk(fpm_pkg::OP_FLASH_INFO, 15, 0, 0));
        send_req(mk(fpm_pkg::OP_FLASH_INFO, 29, 0, 0));
        send_req(mk(fpm_pkg::OP_FLASH_INFO, 30, 0, 0));
        send_req(mk(fpm_pkg::OP_FLASH_INFO, 18'h3FFFF, 0, 0));
        send_req(mk(fpm_pkg::OP_QUERY, 0, 32'h1000_7C00, 0));
        send_req(mk(fpm_pkg::OP_QUERY, 0, 32'h1000_7C01, 0));
        send_req(mk(fpm_pkg::OP_QUERY, 0, 32'h2008_3FFF, 0));
        send_req(mk(fpm_pkg::OP_QUERY, 0, 32'h0008_0000, 0));
        send_req(mk(fpm_pkg::OP_QUERY, 0, 32'h0008_0001, 0));
        send_req(mk(fpm_pkg::OP_QUERY, 0, 32'h0000_FFFF, 0));
        send_req(mk(fpm_pkg::OP_QUERY, 0, 32'hFFFF_FFFF, 0));
        send_req(mk(fpm_pkg::OP_ERASE_CHECK, 0, 0, 0));
        send_req(mk(fpm_pkg::OP_ERASE_CHECK, 1, 0, 0));
        send_req(mk(fpm_pkg::OP_WRITE_CHECK, 0, 32'h1000_0000, 16'hFFFF));
        send_req(mk(fpm_pkg::OP_WRITE_CHECK, 0, 32'h1000_7FFF, 16'd1));
        send_req(mk(fpm_pkg::OP_WRITE_CHECK, 0, 32'h1000_7FFF, 16'd0));
        send_req(mk(fpm_pkg::OP_WRITE_CHECK, 0, 32'h0007_FF00, 16'd5));
        send_req(mk(fpm_pkg::OP_WRITE_CHECK, 0, 32'h0007_FF01, 16'd5));
        send_req(mk(fpm_pkg::OP_WRITE_CHECK, 0, 32'h0008_0000, 16'd256));
        send_req(mk(OP_UNUSED, 18'h3FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        random_phase(PHASE_ITEMS);

        // boot code up to 0x5000 and an OS image in the first large sectors
        configure(fpm_pkg::RST_MAIN_RAM_BASE, 32, fpm_pkg::RST_AUX_RAM_BASE, 32,
                  32'h0008_0000, 32'h0000_5000, 32'h0001_0000, 32'h0002_FFFF);
        random_phase(PHASE_ITEMS);

        // upper extremes, run without any idling
        calm = 1'b1;
        configure(32'hFFFF_FC00, 1024, 32'hFFFF_FFFF, 1024, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);
        calm = 1'b0;

        configure(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
        random_phase(PHASE_ITEMS);

        // regions overlap each other and the flash; boot edge on the first large sector
        configure(32'h0000_8000, 64, 32'h0000_C000, 16, 32'h0010_0000,
                  32'h0001_0000, 32'h0001_8000, 32'h0002_0000);
        random_phase(PHASE_ITEMS);

        repeat (2) begin
            configure($urandom_range(0, 32'h0008_0000), $urandom_range(0, 1024), $urandom,
                      $urandom_range(0, 1024), $urandom_range(0, 32'h0040_0000),
                      $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(0, 32'h0004_0000),
                      $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0014_0000));
            random_phase(PHASE_ITEMS / 2);
        end

        repeat (8) @(posedge i_clk);
        $display("tb: %0d requests over %0d register settings, %0d results compared",
                 board.accepted, settings_seen, board.checked);
        if (board.errors == 0) begin
            $display("flash_ram_page_mapper: match");
        end else begin
            $display("flash_ram_page_mapper: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: run did not complete in time");
        $display("flash_ram_page_mapper: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/fpm_pkg.sv
rtl/fpm_cfg_regs.sv
rtl/fpm_map_logic.sv
rtl/flash_ram_page_mapper.sv
rtl/fpm_checker.sv
bench/tb.sv
